FILE: rtl/core/dsds_pkg.sv
// Package for the data stack: operation and status codes, sequencer states and the result word.
`default_nettype none

package dsds_pkg;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_DUP  = 3'd2,
    OP_SWAP = 3'd3,
    OP_ROT  = 3'd4,
    OP_PEEK = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_UNDER  = 2'd1,
    ST_OVER   = 2'd2,
    ST_BADOFS = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_CAP1,
    S_RD2,
    S_RD3,
    S_SW_W1,
    S_SW_W2,
    S_RT_W1,
    S_RT_W2,
    S_RT_W3,
    S_RESULT
  } seq_state_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [6:0]  depth_after;
    status_t     status;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/dsds_mem.sv
// Stack entry storage: one write port and one registered read port.
`default_nettype none

module dsds_mem
  import dsds_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int WORD_WIDTH  = 32,
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WORD_WIDTH-1:0] wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr,
  output logic      [WORD_WIDTH-1:0] rdata
);

  logic [WORD_WIDTH-1:0] mem [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/core/dsds_ctrl.sv
// Stack sequencer: checks each operation, reads the entries it needs and writes them back.
`default_nettype none

module dsds_ctrl
  import dsds_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int WORD_WIDTH  = 32,
  localparam int AW = $clog2(STACK_DEPTH),
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic [2:0]            in_op,
  input  wire logic [31:0]           in_push_value,
  input  wire logic [5:0]            in_peek_offset,
  output logic                       in_stall,
  output logic                       mem_we,
  output logic      [AW-1:0]         mem_waddr,
  output logic      [WORD_WIDTH-1:0] mem_wdata,
  output logic                       mem_re,
  output logic      [AW-1:0]         mem_raddr,
  input  wire logic [WORD_WIDTH-1:0] mem_rdata,
  output logic                       res_valid,
  output result_t                    res,
  input  wire logic                  res_ready
);

  localparam int CMPW = (CW > 6) ? CW : 6;

  seq_state_t            state_r, state_nxt;
  op_t                   op_r;
  logic [WORD_WIDTH-1:0] val_r;
  logic [5:0]            ofs_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [WORD_WIDTH-1:0] t0_r, t0_nxt;
  logic [WORD_WIDTH-1:0] t1_r, t1_nxt;
  logic [31:0]           rd_r, rd_nxt;
  status_t               st_r, st_nxt;
  status_t               chk_st;
  logic                  accept;
  logic                  empty, full;
  logic [AW-1:0]         push_addr, top_addr, sec_addr, thr_addr, peek_addr;

  assign accept    = in_valid && !in_stall;
  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(STACK_DEPTH));
  assign push_addr = AW'(count_r);
  assign top_addr  = AW'(count_r - CW'(1));
  assign sec_addr  = AW'(count_r - CW'(2));
  assign thr_addr  = AW'(count_r - CW'(3));
  assign peek_addr = AW'(count_r - CW'(1) - CW'(ofs_r));

  // Status of the held operation against the current depth.
  always_comb begin
    chk_st = ST_OK;
    case (op_r)
      OP_PUSH: if (full) chk_st = ST_OVER;
      OP_POP:  if (empty) chk_st = ST_UNDER;
      OP_DUP: begin
        if (empty) begin
          chk_st = ST_UNDER;
        end else if (full) begin
          chk_st = ST_OVER;
        end
      end
      OP_SWAP: if (count_r < CW'(2)) chk_st = ST_UNDER;
      OP_ROT:  if (count_r < CW'(3)) chk_st = ST_UNDER;
      OP_PEEK: if (CMPW'(ofs_r) >= CMPW'(count_r)) chk_st = ST_BADOFS;
      default: chk_st = ST_OK;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_CHECK;
      S_CHECK: begin
        if (chk_st != ST_OK) begin
          state_nxt = S_RESULT;
        end else begin
          case (op_r)
            OP_POP, OP_DUP, OP_PEEK: state_nxt = S_CAP1;
            OP_SWAP, OP_ROT:         state_nxt = S_RD2;
            default:                 state_nxt = S_RESULT;
          endcase
        end
      end
      S_CAP1:  state_nxt = S_RESULT;
      S_RD2:   state_nxt = (op_r == OP_SWAP) ? S_SW_W1 : S_RD3;
      S_SW_W1: state_nxt = S_SW_W2;
      S_SW_W2: state_nxt = S_RESULT;
      S_RD3:   state_nxt = S_RT_W1;
      S_RT_W1: state_nxt = S_RT_W2;
      S_RT_W2: state_nxt = S_RT_W3;
      S_RT_W3: state_nxt = S_RESULT;
      S_RESULT: if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory requests and datapath updates.
  always_comb begin
    count_nxt = count_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    rd_nxt    = rd_r;
    st_nxt    = st_r;
    mem_we    = 1'b0;
    mem_waddr = push_addr;
    mem_wdata = val_r;
    mem_re    = 1'b0;
    mem_raddr = top_addr;
    in_stall  = (state_r != S_IDLE);
    res_valid = 1'b0;
    case (state_r)
      S_CHECK: begin
        rd_nxt = '0;
        st_nxt = chk_st;
        if (chk_st == ST_OK) begin
          case (op_r)
            OP_PUSH: begin
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end
            OP_POP, OP_DUP, OP_SWAP, OP_ROT: mem_re = 1'b1;
            OP_PEEK: begin
              mem_re    = 1'b1;
              mem_raddr = peek_addr;
            end
            default: mem_re = 1'b0;
          endcase
        end
      end
      S_CAP1: begin
        case (op_r)
          OP_POP: begin
            rd_nxt    = 32'(mem_rdata);
            count_nxt = count_r - CW'(1);
          end
          OP_DUP: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata;
            count_nxt = count_r + CW'(1);
          end
          default: rd_nxt = 32'(mem_rdata);
        endcase
      end
      S_RD2: begin
        t0_nxt    = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = sec_addr;
      end
      S_SW_W1, S_RT_W1: begin
        mem_we    = 1'b1;
        mem_waddr = top_addr;
        mem_wdata = mem_rdata;
      end
      S_SW_W2, S_RT_W2: begin
        mem_we    = 1'b1;
        mem_waddr = sec_addr;
        mem_wdata = t0_r;
      end
      S_RD3: begin
        t1_nxt    = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = thr_addr;
      end
      S_RT_W3: begin
        mem_we    = 1'b1;
        mem_waddr = thr_addr;
        mem_wdata = t1_r;
      end
      S_RESULT: res_valid = 1'b1;
      default: res_valid = 1'b0;
    endcase
  end

  assign res.read_value  = rd_r;
  assign res.depth_after = 7'(count_r);
  assign res.status      = st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(in_op);
      val_r <= WORD_WIDTH'(in_push_value);
      ofs_r <= in_peek_offset;
    end
    t0_r <= t0_nxt;
    t1_r <= t1_nxt;
    rd_r <= rd_nxt;
    st_r <= st_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/core/dsds_out.sv
// Output register for result words, parting the sequencer from the consumer's stall.
`default_nettype none

module dsds_out
  import dsds_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    res_valid,
  input  wire result_t res,
  output logic         res_ready,
  output logic         out_valid,
  output logic [31:0]  out_read_value,
  output logic [6:0]   out_depth_after,
  output logic [1:0]   out_status,
  input  wire logic    out_stall
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign res_ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (res_ready) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data_r <= res;
    end
  end

  assign out_valid       = valid_r;
  assign out_read_value  = data_r.read_value;
  assign out_depth_after = data_r.depth_after;
  assign out_status      = data_r.status;

endmodule

`default_nettype wire

FILE: rtl/core/data_stack_dup_swap_rot_top.sv
// Top level of the data stack with push, pop, dup, swap, rotate and peek operations.
// The stack entries live in a single synchronous memory with one write port and one
// registered read port; a sequencer takes one operation at a time, checks it against
// the current depth, reads the entries it needs and writes them back. Every accepted
// word gives exactly one result word carrying the word popped or peeked (zero otherwise),
// the depth after the operation and a status code: ok, underflow, overflow or a peek
// offset beyond the depth. A failing operation leaves the stack untouched. An operation
// occupies the sequencer from acceptance until its result is taken by the output register;
// push, failing operations and unused codes need the fewest states, then pop, dup and
// peek, then swap, and rotate the most; the order is set by the memory's single read and
// single write port, through which each entry touched is read and then written back in
// turn. A finished result is parked in the output register, so the next word can be
// accepted while the consumer stalls. The depth output is seven bits wide and exact for
// STACK_DEPTH up to 127. No clearing pass is needed after reset: entries at or above
// the depth are never read.
`default_nettype none

module data_stack_dup_swap_rot_top
  import dsds_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int WORD_WIDTH  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [2:0]  in_op,
  input  wire logic [31:0] in_push_value,
  input  wire logic [5:0]  in_peek_offset,
  output logic             in_stall,
  output logic             out_valid,
  output logic [31:0]      out_read_value,
  output logic [6:0]       out_depth_after,
  output logic [1:0]       out_status,
  input  wire logic        out_stall
);

  localparam int AW = $clog2(STACK_DEPTH);

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WORD_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [WORD_WIDTH-1:0] mem_rdata;
  logic                  res_valid;
  logic                  res_ready;
  result_t               res;

  // Entry storage: entry 0 is the bottom of the stack.
  dsds_mem #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer holding the depth and walking each operation through the memory.
  dsds_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_op          (in_op),
    .in_push_value  (in_push_value),
    .in_peek_offset (in_peek_offset),
    .in_stall       (in_stall),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata),
    .res_valid      (res_valid),
    .res            (res),
    .res_ready      (res_ready)
  );

  // Result register facing the consumer.
  dsds_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res_valid),
    .res             (res),
    .res_ready       (res_ready),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_depth_after (out_depth_after),
    .out_status      (out_status),
    .out_stall       (out_stall)
  );

endmodule

`default_nettype wire

FILE: dv/data_stack_checker.sv
// Checker for the data stack: tracks the stack from accepted words and compares every result.
`timescale 1ns / 100ps

module data_stack_checker
  import dsds_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_push_value,
  input  logic [5:0]  in_peek_offset,
  input  logic        in_stall,
  input  logic        out_valid,
  input  logic [31:0] out_read_value,
  input  logic [6:0]  out_depth_after,
  input  logic [1:0]  out_status,
  input  logic        out_stall,
  output int          fail_count,
  output int          pending_count,
  output int          checked_count,
  output int          peak_depth
);

  logic [31:0] stack_words [STACK_DEPTH];
  int          stack_fill;
  result_t     awaited_results [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    checked_count = 0;
    peak_depth    = 0;
    stack_fill    = 0;
  end

  // Applies one operation to the shadow stack and returns the result it should give.
  task automatic apply_stack_op(input logic [2:0] op, input logic [31:0] push_word,
                                input logic [5:0] offset, output result_t res);
    logic [31:0] x1, x2, x3;
    int n;
    n = stack_fill;
    res.read_value = '0;
    res.status     = ST_OK;
    case (op)
      OP_PUSH: begin
        if (n >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          stack_words[n] = push_word;
          stack_fill = n + 1;
        end
      end
      OP_POP: begin
        if (n == 0) begin
          res.status = ST_UNDER;
        end else begin
          res.read_value = stack_words[n-1];
          stack_fill = n - 1;
        end
      end
      OP_DUP: begin
        if (n == 0) begin
          res.status = ST_UNDER;
        end else if (n >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          stack_words[n] = stack_words[n-1];
          stack_fill = n + 1;
        end
      end
      OP_SWAP: begin
        if (n < 2) begin
          res.status = ST_UNDER;
        end else begin
          x1 = stack_words[n-1];
          stack_words[n-1] = stack_words[n-2];
          stack_words[n-2] = x1;
        end
      end
      OP_ROT: begin
        if (n < 3) begin
          res.status = ST_UNDER;
        end else begin
          // The third entry comes to the top; the upper two move down one place.
          x1 = stack_words[n-1];
          x2 = stack_words[n-2];
          x3 = stack_words[n-3];
          stack_words[n-1] = x3;
          stack_words[n-2] = x1;
          stack_words[n-3] = x2;
        end
      end
      OP_PEEK: begin
        if (int'(offset) >= n) begin
          res.status = ST_BADOFS;
        end else begin
          res.read_value = stack_words[n-1-int'(offset)];
        end
      end
      default: begin
      end
    endcase
    res.depth_after = stack_fill[6:0];
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t fresh;
    if (rst_n) begin
      // Results are matched before new words are taken in, as none can be that fast.
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none awaited: read_value %h depth %0d status %0d",
                   $time, out_read_value, out_depth_after, out_status);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          checked_count++;
          if (out_read_value !== want.read_value) begin
            $display("%0t: read_value expected %h, got %h",
                     $time, want.read_value, out_read_value);
            fail_count++;
          end
          if (out_depth_after !== want.depth_after) begin
            $display("%0t: depth_after expected %0d, got %0d",
                     $time, want.depth_after, out_depth_after);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_stack_op(in_op, in_push_value, in_peek_offset, fresh);
        awaited_results.push_back(fresh);
        if (stack_fill > peak_depth) peak_depth = stack_fill;
      end
      pending_count = awaited_results.size();
    end
  end

endmodule

FILE: dv/data_stack_dup_swap_rot_top_tb.sv
// Testbench top for the data stack: drives operation words, stalls results and gives the verdict.
`timescale 1ns / 100ps

module data_stack_dup_swap_rot_top_tb;
  import dsds_pkg::*;

  localparam int STACK_DEPTH   = 64;
  localparam int RANDOM_WORDS  = 1800;
  // Well above the slowest correct run: every word a rotate behind a full sender gap and
  // a full receiver stall, plus the drain pauses.
  localparam int CYCLE_LIMIT   = 400_000;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic [2:0]  in_op          = OP_PUSH;
  logic [31:0] in_push_value  = '0;
  logic [5:0]  in_peek_offset = '0;
  logic        out_stall      = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] out_read_value;
  logic [6:0]  out_depth_after;
  logic [1:0]  out_status;

  int fail_count;
  int pending_count;
  int checked_count;
  int peak_depth;

  int  words_sent     = 0;
  int  directed_words = 0;
  int  cycle_count    = 0;
  int  stall_left     = 0;
  // When set, the sender offers words back to back and the receiver never stalls.
  bit  tx_burst       = 1'b0;
  bit  rx_quiet       = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  data_stack_dup_swap_rot_top #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_WIDTH  (32)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_op           (in_op),
    .in_push_value   (in_push_value),
    .in_peek_offset  (in_peek_offset),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_depth_after (out_depth_after),
    .out_status      (out_status),
    .out_stall       (out_stall)
  );

  data_stack_checker #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_op           (in_op),
    .in_push_value   (in_push_value),
    .in_peek_offset  (in_peek_offset),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_depth_after (out_depth_after),
    .out_status      (out_status),
    .out_stall       (out_stall),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .checked_count   (checked_count),
    .peak_depth      (peak_depth)
  );

  // A hard stop in case the block hangs or loses a result.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: after each result word is taken, it draws how long to hold stall high
  // before it will take the next one. The count runs down at falling edges, so stall
  // also lands on cycles where no result is on offer.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      stall_left <= rx_quiet ? 0 : $urandom_range(0, 15);
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offers one word after a random gap and returns at the edge where it is taken.
  // With no gap, valid simply stays high and only the payload moves on.
  task automatic send_word(input op_t op, input logic [31:0] push_word,
                           input logic [5:0] offset);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_push_value  <= push_word;
    in_peek_offset <= offset;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Holds the sender off until every result it has caused has come back.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Push share in percent; dup rides along with push so that a high share fills the stack.
  function automatic op_t pick_op(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return ($urandom_range(0, 4) == 0) ? OP_DUP : OP_PUSH;
    r = $urandom_range(0, 99);
    if (r < 40) return OP_POP;
    if (r < 70) return OP_PEEK;
    if (r < 85) return OP_SWAP;
    return OP_ROT;
  endfunction

  // Push data leans on the all-zeros and all-ones words now and then.
  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Peek offsets are mostly near the top, where they usually hit, but span the full field.
  function automatic logic [5:0] pick_offset();
    if ($urandom_range(0, 1) == 0) return 6'($urandom_range(0, 7));
    return 6'($urandom_range(0, 63));
  endfunction

  initial begin
    int phase;
    int phase_len;
    int push_pct;
    int random_words;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: every operation failing on an empty or shallow stack, rotate and
    // swap at their smallest legal depth, the extremes of the push word, and peeks at
    // the top, at the bottom and just past it.
    send_word(OP_POP,  '0, '0);
    send_word(OP_DUP,  '0, '0);
    send_word(OP_SWAP, '0, '0);
    send_word(OP_ROT,  '0, '0);
    send_word(OP_PEEK, '0, 6'd0);
    send_word(OP_PUSH, 32'h0000_0000, '0);
    send_word(OP_SWAP, '0, '0);
    send_word(OP_ROT,  '0, '0);
    send_word(OP_PUSH, 32'hFFFF_FFFF, 6'd63);
    send_word(OP_ROT,  '0, '0);
    send_word(OP_SWAP, '0, '0);
    send_word(OP_PUSH, 32'hA5A5_5A5A, '0);
    send_word(OP_ROT,  '0, '0);
    send_word(OP_DUP,  '0, '0);
    send_word(OP_PEEK, '0, 6'd0);
    send_word(OP_PEEK, '0, 6'd3);
    send_word(OP_PEEK, '0, 6'd4);
    send_word(OP_PEEK, '0, 6'd63);
    repeat (5) send_word(OP_POP, '0, '0);
    directed_words = words_sent;

    // Let the block run dry once before the random part starts.
    wait_for_results();

    // Random part in phases. Every sixth phase fills the stack past full for overflow and
    // deep peeks, and the next sends no pushes, so pops take it down; the others drift up
    // or down at a random push share. Idling style changes per phase.
    phase        = 0;
    random_words = 0;
    while (random_words < RANDOM_WORDS) begin
      case (phase % 6)
        0: begin
          push_pct  = 100;
          phase_len = STACK_DEPTH + 8;
        end
        1: begin
          push_pct  = 0;
          phase_len = STACK_DEPTH + 8;
        end
        default: begin
          push_pct  = 5 + 22 * $urandom_range(0, 4);
          phase_len = $urandom_range(20, 120);
        end
      endcase
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        send_word(pick_op(push_pct), pick_word(), pick_offset());
        random_words++;
      end
      if ($urandom_range(0, 2) == 0) wait_for_results();
      phase++;
    end

    // Drain, then keep idling past the slowest operation to catch stray results.
    wait_for_results();
    repeat (12) @(negedge clk);

    $display("Run covered %0d words (%0d directed, %0d random phases), %0d results checked,",
             words_sent, directed_words, phase, checked_count);
    $display("with the stack reaching a depth of %0d of %0d entries.", peak_depth, STACK_DEPTH);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
